/* hw/rtl/register_datagram_uart_framer_core_assert.svh */
// Assertion macros shared by the framer core modules.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef REGISTER_DATAGRAM_UART_FRAMER_CORE_ASSERT_SVH
`define REGISTER_DATAGRAM_UART_FRAMER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDUF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rduf_pkg.sv */
`default_nettype none

package rduf_pkg;

  // Action codes carried on the input tuser.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic KIND_TX       = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // Register indexes on the configuration channel.
  localparam logic REG_NODE_ADDRESS   = 1'b0;
  localparam logic REG_CRC_POLYNOMIAL = 1'b1;

  localparam logic [7:0] NODE_ADDRESS_RESET = 8'h00;
  localparam logic [7:0] CRC_POLY_RESET     = 8'h07;

  // Datagram sync bytes.
  localparam logic [7:0] WRITE_SYNC = 8'hA5;
  localparam logic [7:0] READ_SYNC  = 8'h55;
  localparam logic [7:0] RESP_SYNC  = 8'h05;

  // Bytes after the sync byte that precede the CRC byte.
  localparam logic [2:0] WRITE_BODY_BYTES = 3'd6;
  localparam logic [2:0] READ_BODY_BYTES  = 3'd2;

  // Receive counts loaded when a sync byte is seen in idle.
  localparam logic [2:0] WRITE_ECHO_LEFT = 3'd7;
  localparam logic [2:0] READ_ECHO_LEFT  = 3'd3;
  localparam logic [2:0] RESP_LEFT       = 3'd7;

  typedef enum logic [1:0] {
    RX_IDLE    = 2'd0,
    RX_SKIP    = 2'd1,
    RX_COLLECT = 2'd2
  } rx_phase_t;

  // Control from the top level to the transmit framer.
  typedef struct packed {
    logic start;
    logic advance;
    logic is_write;
  } fr_ctrl_t;

  // Byte the framer presents in the current cycle, and whether it has more.
  typedef struct packed {
    logic       busy;
    logic       last;
    logic [7:0] data;
  } fr_stat_t;

  // Completed response from the receive deframer.
  typedef struct packed {
    logic        valid;
    logic        crc_ok;
    logic [31:0] data;
  } rx_res_t;

  // CRC-8, left shifting, data bits taken LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rduf_tx_framer.sv */
`default_nettype none
`include "register_datagram_uart_framer_core_assert.svh"

module rduf_tx_framer
  import rduf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  node_address,
  input  wire logic [7:0]  crc_polynomial,
  input  wire logic [7:0]  reg_address,
  input  wire logic [31:0] write_value,
  input  wire fr_ctrl_t    ctrl,
  output fr_stat_t         stat
);

  logic        busy;
  logic        busy_next;
  logic [2:0]  left;
  logic [2:0]  left_next;
  logic [47:0] body;
  logic [47:0] body_next;
  logic [7:0]  crc;
  logic [7:0]  crc_next;
  logic [7:0]  sync;

  assign sync = ctrl.is_write ? WRITE_SYNC : READ_SYNC;

  always_comb begin
    busy_next = busy;
    left_next = left;
    body_next = body;
    crc_next  = crc;
    stat.busy = busy;
    stat.last = 1'b0;
    stat.data = body[47:40];
    if (ctrl.start) begin
      // The sync byte leaves now; the rest waits in the body shifter.
      stat.data = sync;
      busy_next = 1'b1;
      left_next = ctrl.is_write ? WRITE_BODY_BYTES : READ_BODY_BYTES;
      body_next = {node_address, reg_address,
                   (ctrl.is_write ? write_value : 32'h0000_0000)};
      crc_next  = crc8_byte(8'h00, sync, crc_polynomial);
    end else if (left == 3'd0) begin
      stat.data = crc;
      stat.last = 1'b1;
      if (ctrl.advance) begin
        busy_next = 1'b0;
      end
    end else if (ctrl.advance) begin
      crc_next  = crc8_byte(crc, body[47:40], crc_polynomial);
      body_next = {body[39:0], 8'h00};
      left_next = left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= 3'd0;
    end else begin
      busy <= busy_next;
      left <= left_next;
    end
    body <= body_next;
    crc  <= crc_next;
  end

  `RDUF_ASSERT_NEXT(a_start_busy, ctrl.start, busy, "framer did not go busy after start")
  `RDUF_ASSERT_NEXT(a_crc_ends, busy && ctrl.advance && left == 3'd0 && !ctrl.start, !busy,
                    "framer still busy after its CRC byte")

endmodule

`default_nettype wire

/* hw/rtl/rduf_rx_deframer.sv */
`default_nettype none
`include "register_datagram_uart_framer_core_assert.svh"

module rduf_rx_deframer
  import rduf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] crc_polynomial,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output rx_res_t         res
);

  rx_phase_t   phase;
  rx_phase_t   phase_next;
  logic [2:0]  remaining;
  logic [2:0]  remaining_next;
  logic [7:0]  crc;
  logic [7:0]  crc_next;
  logic [31:0] payload;
  logic [31:0] payload_next;

  // Next state.
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    crc_next       = crc;
    payload_next   = payload;
    if (step) begin
      unique case (phase)
        RX_SKIP: begin
          remaining_next = remaining - 3'd1;
          if (remaining_next == 3'd0) begin
            phase_next = RX_IDLE;
          end
        end
        RX_COLLECT: begin
          if (remaining <= 3'd1) begin
            phase_next     = RX_IDLE;
            remaining_next = 3'd0;
          end else begin
            crc_next = crc8_byte(crc, rx_byte, crc_polynomial);
            if (remaining <= 3'd5) begin
              payload_next = {payload[23:0], rx_byte};
            end
            remaining_next = remaining - 3'd1;
          end
        end
        default: begin
          phase_next = RX_IDLE;
          if (rx_byte == WRITE_SYNC) begin
            phase_next     = RX_SKIP;
            remaining_next = WRITE_ECHO_LEFT;
          end else if (rx_byte == READ_SYNC) begin
            phase_next     = RX_SKIP;
            remaining_next = READ_ECHO_LEFT;
          end else if (rx_byte == RESP_SYNC) begin
            phase_next     = RX_COLLECT;
            remaining_next = RESP_LEFT;
            payload_next   = 32'h0000_0000;
            crc_next       = crc8_byte(8'h00, rx_byte, crc_polynomial);
          end
        end
      endcase
    end
  end

  // Outputs: a response completes on its CRC byte.
  always_comb begin
    res.valid  = step && phase == RX_COLLECT && remaining <= 3'd1;
    res.crc_ok = rx_byte == crc;
    res.data   = payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= RX_IDLE;
      remaining <= 3'd0;
      crc       <= 8'h00;
      payload   <= 32'h0000_0000;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      crc       <= crc_next;
      payload   <= payload_next;
    end
  end

  `RDUF_ASSERT_SAME(a_skip_count, phase == RX_SKIP, remaining != 3'd0,
                    "echo skip with nothing left to skip")

endmodule

`default_nettype wire

/* hw/rtl/register_datagram_uart_framer_core.sv */
// Register datagram UART framer and deframer with CRC-8.
// Input words arrive on s_*: tuser is the action (write request, read request or
// received line byte) and tdata carries the register address, write data and line byte.
// Result words leave on m_*: tuser is the kind (transmit byte or read response), tlast
// marks the final byte of a datagram and is always set on a response.
// Configuration is written on cfg_*: index 0 is the node address, index 1 the CRC-8
// polynomial; writes are always accepted and should be made while the block is idle.
// An accepted word is held in the input register, and its first result word is registered in
// the output register.
// A write request yields eight transmit words, one per cycle unless the receiver stalls,
// and a read request four; the transmit framer serializes them, so the next word leaves
// the input register once the framer is idle and the output register has room, and
// datagrams follow each other with no gap. A received byte gives at most one word.
// Reset clears the node address to zero, the polynomial to 0x07 and the receive scanner
// to idle, and empties both registers. When the receiver stalls, the output register
// holds its word, the framer pauses and the input register fills, then tready drops.
`default_nettype none
`include "register_datagram_uart_framer_core_assert.svh"

module register_datagram_uart_framer_core
  import rduf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // reg_address[7:0], write_value[39:8], rx_byte[47:40]
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // tx_byte[7:0], read_value[39:8], crc_ok[40], zero
  output logic [0:0]       m_tuser,   // kind[0]
  output logic             m_tlast,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]  node_address;
  logic [7:0]  crc_polynomial;

  // Input register.
  logic        in_valid;
  logic [1:0]  in_action;
  logic [7:0]  in_addr;
  logic [31:0] in_wvalue;
  logic [7:0]  in_rbyte;

  // Output register.
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_tx;
  logic        out_last;
  logic [31:0] out_rvalue;
  logic        out_crc_ok;

  logic        out_ok;
  logic        in_take;
  logic        is_req;
  fr_ctrl_t    fr_ctrl;
  fr_stat_t    fr_stat;
  rx_res_t     rx_res;
  logic        rx_step;
  logic        tx_emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address   <= NODE_ADDRESS_RESET;
      crc_polynomial <= CRC_POLY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NODE_ADDRESS:   node_address   <= cfg_data;
        REG_CRC_POLYNOMIAL: crc_polynomial <= cfg_data;
        default: ;
      endcase
    end
  end

  // The output register can take a word when it is empty or being drained.
  assign out_ok   = !out_valid || m_tready;
  // An item leaves the input register only when the framer has nothing left to send.
  assign in_take  = in_valid && out_ok && !fr_stat.busy;
  assign s_tready = !in_valid || in_take;
  assign is_req   = in_action == ACT_WRITE || in_action == ACT_READ;
  assign rx_step  = in_take && in_action == ACT_RX;

  assign fr_ctrl.start    = in_take && is_req;
  assign fr_ctrl.advance  = out_ok && fr_stat.busy;
  assign fr_ctrl.is_write = in_action == ACT_WRITE;
  assign tx_emit          = fr_ctrl.start || fr_ctrl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_take) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_addr   <= s_tdata[7:0];
      in_wvalue <= s_tdata[39:8];
      in_rbyte  <= s_tdata[47:40];
    end
  end

  rduf_tx_framer u_tx_framer (
    .clk            (clk),
    .rst            (rst),
    .node_address   (node_address),
    .crc_polynomial (crc_polynomial),
    .reg_address    (in_addr),
    .write_value    (in_wvalue),
    .ctrl           (fr_ctrl),
    .stat           (fr_stat)
  );

  rduf_rx_deframer u_rx_deframer (
    .clk            (clk),
    .rst            (rst),
    .crc_polynomial (crc_polynomial),
    .step           (rx_step),
    .rx_byte        (in_rbyte),
    .res            (rx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tx_emit || rx_res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ok) begin
      out_valid <= 1'b0;
    end
    if (tx_emit) begin
      out_kind   <= KIND_TX;
      out_tx     <= fr_stat.data;
      out_last   <= fr_stat.last;
      out_rvalue <= 32'h0000_0000;
      out_crc_ok <= 1'b0;
    end else if (rx_res.valid) begin
      out_kind   <= KIND_RESPONSE;
      out_tx     <= 8'h00;
      out_last   <= 1'b1;
      out_rvalue <= rx_res.data;
      out_crc_ok <= rx_res.crc_ok;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {7'b0, out_crc_ok, out_rvalue, out_tx};
  assign m_tuser[0] = out_kind;
  assign m_tlast    = out_last;

  `RDUF_ASSERT_SAME(a_one_source, tx_emit, !rx_res.valid,
                    "framer and deframer produced a word in the same cycle")
  `RDUF_ASSERT_SAME(a_load_room, tx_emit || rx_res.valid, out_ok,
                    "result loaded while the output register is stalled")
  `RDUF_ASSERT_SAME(a_resp_last, m_tvalid && m_tuser[0] == KIND_RESPONSE, m_tlast,
                    "response word without last")

endmodule

`default_nettype wire
